// ===== design/jsbm_pkg.sv =====
// Shared constants for the JSON structural bracket matcher.
`default_nettype none

package jsbm_pkg;

   localparam int DEFAULT_STACK_DEPTH = 64;
   localparam int DEFAULT_POS_BITS    = 16;

   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;

   localparam logic [1:0] KIND_BRACE  = 2'd0;
   localparam logic [1:0] KIND_SQUARE = 2'd1;
   localparam logic [1:0] KIND_STRING = 2'd2;

   localparam logic [1:0] ERR_OK         = 2'd0;
   localparam logic [1:0] ERR_NO_OPEN    = 2'd1;
   localparam logic [1:0] ERR_STACK_FULL = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG   = 2'd3;

endpackage

`default_nettype wire

// ===== design/json_structural_bracket_matcher_core.sv =====
// Top level of the JSON structural bracket matcher: byte register, match logic, result register.
// A byte passes through the input register, then the match logic into the result register.
// Throughput: one byte per cycle, kept by the bypassed top-of-stack read on each bracket
// stack; only a stalled result slows acceptance.
// Reset (synchronous, active high) clears position, string state, stack counts and both
// valid flags; stack memories are not cleared, entries above the count are never used.
`default_nettype none

module json_structural_bracket_matcher_core #(
   parameter int STACK_DEPTH = jsbm_pkg::DEFAULT_STACK_DEPTH,
   parameter int POS_BITS    = jsbm_pkg::DEFAULT_POS_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [7:0]          req_text_byte,
   input  wire logic                req_start_of_text,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [1:0]          rsp_pair_kind,
   output      logic [POS_BITS-1:0] rsp_open_position,
   output      logic [POS_BITS-1:0] rsp_close_position,
   output      logic [1:0]          rsp_error_code
);

   import jsbm_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_sot_ff;

   // Scan state.
   logic [POS_BITS:0]   pos_ff, pos_in;
   logic                in_str_ff, in_str_in;
   logic                esc_ff, esc_in;
   logic [POS_BITS-1:0] str_start_ff, str_start_in;
   logic [CW-1:0]       bcnt_ff, bcnt_in;
   logic [CW-1:0]       scnt_ff, scnt_in;

   // Stack memories with a registered read of the current top.
   logic [POS_BITS-1:0] bmem [STACK_DEPTH];
   logic [POS_BITS-1:0] smem [STACK_DEPTH];
   logic [POS_BITS-1:0] brd_ff, srd_ff;
   logic                bbyp_ff, sbyp_ff;
   logic [POS_BITS-1:0] byp_data_ff;
   logic [POS_BITS-1:0] btop, stop;
   logic [AW-1:0]       braddr, sraddr;
   logic [CW-1:0]       bcnt_m1, scnt_m1;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          kind_ff, err_ff;
   logic [POS_BITS-1:0] open_ff, close_ff;

   // Match logic.
   logic                adv;
   logic [POS_BITS:0]   pos_base;
   logic                in_str_base, esc_base;
   logic [CW-1:0]       bcnt_base, scnt_base;
   logic [POS_BITS-1:0] cur;
   logic                bpush, spush;
   logic                res_valid;
   logic [1:0]          res_kind, res_err;
   logic [POS_BITS-1:0] res_open, res_close;

   assign adv       = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign btop      = bbyp_ff ? byp_data_ff : brd_ff;
   assign stop      = sbyp_ff ? byp_data_ff : srd_ff;

   always_comb begin
      pos_base     = in_sot_ff ? '0 : pos_ff;
      in_str_base  = in_sot_ff ? 1'b0 : in_str_ff;
      esc_base     = in_sot_ff ? 1'b0 : esc_ff;
      bcnt_base    = in_sot_ff ? '0 : bcnt_ff;
      scnt_base    = in_sot_ff ? '0 : scnt_ff;
      cur          = pos_base[POS_BITS-1:0];
      pos_in       = pos_base;
      in_str_in    = in_str_base;
      esc_in       = esc_base;
      str_start_in = in_sot_ff ? '0 : str_start_ff;
      bcnt_in      = bcnt_base;
      scnt_in      = scnt_base;
      bpush        = 1'b0;
      spush        = 1'b0;
      res_valid    = 1'b0;
      res_kind     = KIND_BRACE;
      res_err      = ERR_OK;
      res_open     = '0;
      res_close    = '0;
      if (pos_base[POS_BITS]) begin
         // Position range exhausted: every byte reports until the next start of text.
         res_valid = 1'b1;
         res_err   = ERR_TOO_LONG;
         res_close = '1;
      end else begin
         pos_in = pos_base + 1'b1;
         if (in_str_base) begin
            if (in_byte_ff == CH_BSLASH) begin
               esc_in = !esc_base;
            end else if (in_byte_ff == CH_QUOTE && !esc_base) begin
               in_str_in = 1'b0;
               res_valid = 1'b1;
               res_kind  = KIND_STRING;
               res_open  = str_start_ff;
               res_close = cur;
            end else begin
               esc_in = 1'b0;
            end
         end else begin
            case (in_byte_ff)
               CH_QUOTE: begin
                  in_str_in    = 1'b1;
                  str_start_in = cur;
                  esc_in       = 1'b0;
               end
               CH_LBRACE: begin
                  if (bcnt_base == FULL_COUNT) begin
                     res_valid = 1'b1;
                     res_err   = ERR_STACK_FULL;
                     res_open  = cur;
                  end else begin
                     bpush   = 1'b1;
                     bcnt_in = bcnt_base + 1'b1;
                  end
               end
               CH_LSQUARE: begin
                  res_kind = KIND_SQUARE;
                  if (scnt_base == FULL_COUNT) begin
                     res_valid = 1'b1;
                     res_err   = ERR_STACK_FULL;
                     res_open  = cur;
                  end else begin
                     spush   = 1'b1;
                     scnt_in = scnt_base + 1'b1;
                  end
               end
               CH_RBRACE: begin
                  res_valid = 1'b1;
                  res_close = cur;
                  if (bcnt_base == '0) begin
                     res_err = ERR_NO_OPEN;
                  end else begin
                     res_open = btop;
                     bcnt_in  = bcnt_base - 1'b1;
                  end
               end
               CH_RSQUARE: begin
                  res_valid = 1'b1;
                  res_kind  = KIND_SQUARE;
                  res_close = cur;
                  if (scnt_base == '0) begin
                     res_err = ERR_NO_OPEN;
                  end else begin
                     res_open = stop;
                     scnt_in  = scnt_base - 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // The read address follows the count the stack will have after this edge.
   assign bcnt_m1 = (adv ? bcnt_in : bcnt_ff) - 1'b1;
   assign scnt_m1 = (adv ? scnt_in : scnt_ff) - 1'b1;
   assign braddr  = bcnt_m1[AW-1:0];
   assign sraddr  = scnt_m1[AW-1:0];

   always_ff @(posedge clock) begin
      if (adv && bpush) begin
         bmem[bcnt_base[AW-1:0]] <= cur;
      end
      if (adv && spush) begin
         smem[scnt_base[AW-1:0]] <= cur;
      end
      brd_ff      <= bmem[braddr];
      srd_ff      <= smem[sraddr];
      byp_data_ff <= cur;
   end

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = adv ? res_valid : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         in_str_ff    <= 1'b0;
         esc_ff       <= 1'b0;
         str_start_ff <= '0;
         bcnt_ff      <= '0;
         scnt_ff      <= '0;
         bbyp_ff      <= 1'b0;
         sbyp_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // A push writes the memory at this edge, so the new top comes from the bypass.
         bbyp_ff      <= adv && bpush;
         sbyp_ff      <= adv && spush;
         if (adv) begin
            pos_ff       <= pos_in;
            in_str_ff    <= in_str_in;
            esc_ff       <= esc_in;
            str_start_ff <= str_start_in;
            bcnt_ff      <= bcnt_in;
            scnt_ff      <= scnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_text_byte;
         in_sot_ff  <= req_start_of_text;
      end
      if (adv) begin
         kind_ff  <= res_kind;
         err_ff   <= res_err;
         open_ff  <= res_open;
         close_ff <= res_close;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pair_kind      = kind_ff;
   assign rsp_open_position  = open_ff;
   assign rsp_close_position = close_ff;
   assign rsp_error_code     = err_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (bcnt_ff <= FULL_COUNT) && (scnt_ff <= FULL_COUNT))
      else $error("stack count exceeds depth");

   a_escape_in_string : assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> in_str_ff)
      else $error("escape pending outside a string");

   a_pos_saturates : assert property (@(posedge clock) disable iff (reset)
      pos_ff[POS_BITS] |-> (pos_ff[POS_BITS-1:0] == '0))
      else $error("position passed its saturation value");

   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && err_ff == ERR_OK) |-> (open_ff < close_ff))
      else $error("matched pair opens after it closes");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !in_valid_ff))
      else $error("valid set right after reset");

endmodule

`default_nettype wire
